[sv/hmap_pkg.sv]
// ----------------------------------------------------------------------------
// hmap_pkg
// Shared request and status codes for the chained hash map.
// ----------------------------------------------------------------------------
package hmap_pkg;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 32;

  // Raw request codes on the input port; the spare code behaves as a lookup
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_ERASE  = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;
  localparam logic [1:0] REQ_SPARE  = 2'd3;

  // Classified operation carried to the back end
  typedef enum logic [1:0] {
    OP_INSERT,
    OP_ERASE,
    OP_LOOKUP
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_UPDATED   = 3'd1,
    ST_ERASED    = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_FULL      = 3'd5
  } status_t;

endpackage

[sv/hmap_front.sv]
// ----------------------------------------------------------------------------
// hmap_front
// Accepts requests, decodes the operation and bucket, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module hmap_front #(
  parameter int unsigned BUCKETS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_req_type,
  input  logic signed [hmap_pkg::KEY_W-1:0]   in_key,
  input  logic signed [hmap_pkg::VAL_W-1:0]   in_value,
  output logic                                q_valid,
  input  logic                                q_pop,
  output hmap_pkg::op_t                       q_op,
  output logic [hmap_pkg::KEY_W-1:0]          q_key,
  output logic [hmap_pkg::VAL_W-1:0]          q_value,
  output logic [$clog2(BUCKETS)-1:0]          q_bucket
);

  localparam int unsigned BW = $clog2(BUCKETS);

  hmap_pkg::op_t               op_r  [2];
  logic [hmap_pkg::KEY_W-1:0]  key_r [2];
  logic [hmap_pkg::VAL_W-1:0]  val_r [2];
  logic                        wr_ptr_r, wr_ptr_nxt;
  logic                        rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                  cnt_r, cnt_nxt;
  hmap_pkg::op_t               op_dec;
  logic                        push_ok, pop_ok;

  always_comb begin
    case (in_req_type)
      hmap_pkg::REQ_INSERT: op_dec = hmap_pkg::OP_INSERT;
      hmap_pkg::REQ_ERASE:  op_dec = hmap_pkg::OP_ERASE;
      default:              op_dec = hmap_pkg::OP_LOOKUP;
    endcase
  end

  assign in_full  = (cnt_r == 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign push_ok  = in_push && !in_full;
  assign pop_ok   = q_pop && q_valid;
  assign q_op     = op_r[rd_ptr_r];
  assign q_key    = key_r[rd_ptr_r];
  assign q_value  = val_r[rd_ptr_r];
  assign q_bucket = key_r[rd_ptr_r][BW-1:0];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r ^ push_ok;
    rd_ptr_nxt = rd_ptr_r ^ pop_ok;
    cnt_nxt    = cnt_r + {1'b0, push_ok} - {1'b0, pop_ok};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_ok) begin
      op_r[wr_ptr_r]  <= op_dec;
      key_r[wr_ptr_r] <= in_key;
      val_r[wr_ptr_r] <= in_value;
    end
  end

endmodule

[sv/hmap_back.sv]
// ----------------------------------------------------------------------------
// hmap_back
// Walks the bucket chain through node memory, carries out the request and
// holds the result until it is popped.
// ----------------------------------------------------------------------------
module hmap_back #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned NODES   = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_valid,
  output logic                                q_pop,
  input  hmap_pkg::op_t                       q_op,
  input  logic [hmap_pkg::KEY_W-1:0]          q_key,
  input  logic [hmap_pkg::VAL_W-1:0]          q_value,
  input  logic [$clog2(BUCKETS)-1:0]          q_bucket,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [2:0]                          out_status,
  output logic signed [hmap_pkg::VAL_W-1:0]   out_found_value,
  output logic [$clog2(NODES+1)-1:0]          out_entry_count
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned IW = $clog2(NODES);
  localparam int unsigned NW = $clog2(NODES+1);
  localparam logic [NW-1:0] NONE = NW'(NODES);

  typedef enum logic [2:0] {
    S_IDLE, S_HEAD, S_WALK, S_DO, S_ALLOC, S_UNLINK
  } state_t;

  // Node and bucket memories
  logic [hmap_pkg::KEY_W-1:0] key_mem  [NODES];
  logic [hmap_pkg::VAL_W-1:0] val_mem  [NODES];
  logic [NW-1:0]              link_mem [NODES];
  logic [NW-1:0]              head_mem [BUCKETS];
  logic [BUCKETS-1:0]         hvld_r;
  logic [hmap_pkg::KEY_W-1:0] key_q;
  logic [hmap_pkg::VAL_W-1:0] val_q;
  logic [NW-1:0]              link_q;
  logic [NW-1:0]              head_q;

  state_t                     state_r, state_nxt;
  hmap_pkg::op_t              op_r, op_nxt;
  logic [hmap_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [hmap_pkg::VAL_W-1:0] val_r, val_nxt;
  logic [BW-1:0]              bkt_r, bkt_nxt;
  logic [NW-1:0]              head_r, head_nxt;
  logic [NW-1:0]              cur_r, cur_nxt;
  logic [NW-1:0]              prev_r, prev_nxt;
  logic                       hit_r, hit_nxt;
  logic [NW-1:0]              hitlink_r, hitlink_nxt;
  logic [hmap_pkg::VAL_W-1:0] hitval_r, hitval_nxt;
  logic [NW-1:0]              free_r, free_nxt;
  logic [NW-1:0]              hw_r, hw_nxt;
  logic [NW-1:0]              cnt_r, cnt_nxt;
  logic                       res_vld_r, res_vld_nxt;
  hmap_pkg::status_t          res_st_r, res_st_nxt;
  logic [hmap_pkg::VAL_W-1:0] res_val_r, res_val_nxt;
  logic [NW-1:0]              res_cnt_r, res_cnt_nxt;

  logic [IW-1:0]              rd_addr;
  logic [NW-1:0]              head_cur;
  logic                       link_en;
  logic [NW-1:0]              link_node;
  logic                       vw_en;
  logic                       lw_en;
  logic [IW-1:0]              lw_addr;
  logic [NW-1:0]              lw_data;
  logic                       hw_en;
  logic [NW-1:0]              hw_data;

  assign head_cur = hvld_r[bkt_r] ? head_q : NONE;

  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    key_nxt     = key_r;
    val_nxt     = val_r;
    bkt_nxt     = bkt_r;
    head_nxt    = head_r;
    cur_nxt     = cur_r;
    prev_nxt    = prev_r;
    hit_nxt     = hit_r;
    hitlink_nxt = hitlink_r;
    hitval_nxt  = hitval_r;
    free_nxt    = free_r;
    hw_nxt      = hw_r;
    cnt_nxt     = cnt_r;
    res_vld_nxt = res_vld_r;
    res_st_nxt  = res_st_r;
    res_val_nxt = res_val_r;
    res_cnt_nxt = res_cnt_r;
    q_pop       = 1'b0;
    rd_addr     = '0;
    link_en     = 1'b0;
    link_node   = hw_r;
    vw_en       = 1'b0;
    lw_en       = 1'b0;
    lw_addr     = prev_r[IW-1:0];
    lw_data     = hitlink_r;
    hw_en       = 1'b0;
    hw_data     = hitlink_r;

    if (out_pop && res_vld_r) begin
      res_vld_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (q_valid && !res_vld_r) begin
          q_pop     = 1'b1;
          op_nxt    = q_op;
          key_nxt   = q_key;
          val_nxt   = q_value;
          bkt_nxt   = q_bucket;
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_nxt = head_cur;
        cur_nxt  = head_cur;
        prev_nxt = NONE;
        hit_nxt  = 1'b0;
        rd_addr  = head_cur[IW-1:0];
        state_nxt = (head_cur >= NONE) ? S_DO : S_WALK;
      end
      S_WALK: begin
        if (key_q == key_r) begin
          hit_nxt     = 1'b1;
          hitlink_nxt = link_q;
          hitval_nxt  = val_q;
          state_nxt   = S_DO;
        end else if (link_q >= NONE) begin
          state_nxt = S_DO;
        end else begin
          prev_nxt = cur_r;
          cur_nxt  = link_q;
          rd_addr  = link_q[IW-1:0];
        end
      end
      S_DO: begin
        state_nxt   = S_IDLE;
        res_vld_nxt = 1'b1;
        res_val_nxt = '0;
        res_cnt_nxt = cnt_r;
        case (op_r)
          hmap_pkg::OP_INSERT: begin
            if (hit_r) begin
              vw_en      = 1'b1;
              res_st_nxt = hmap_pkg::ST_UPDATED;
            end else if (cnt_r == NONE) begin
              res_st_nxt = hmap_pkg::ST_FULL;
            end else if (free_r != NONE) begin
              // fetch the next free node before linking
              rd_addr     = free_r[IW-1:0];
              res_vld_nxt = 1'b0;
              state_nxt   = S_ALLOC;
            end else begin
              link_en   = 1'b1;
              link_node = hw_r;
              hw_nxt    = hw_r + 1'b1;
            end
          end
          hmap_pkg::OP_ERASE: begin
            if (hit_r) begin
              if (prev_r == NONE) begin
                hw_en = 1'b1;
              end else begin
                lw_en = 1'b1;
              end
              res_vld_nxt = 1'b0;
              state_nxt   = S_UNLINK;
            end else begin
              res_st_nxt = hmap_pkg::ST_NOT_FOUND;
            end
          end
          default: begin
            if (hit_r) begin
              res_st_nxt  = hmap_pkg::ST_FOUND;
              res_val_nxt = hitval_r;
            end else begin
              res_st_nxt = hmap_pkg::ST_NOT_FOUND;
            end
          end
        endcase
      end
      S_ALLOC: begin
        link_en     = 1'b1;
        link_node   = free_r;
        free_nxt    = link_q;
        res_vld_nxt = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_UNLINK: begin
        // push the erased node on the free list
        lw_en       = 1'b1;
        lw_addr     = cur_r[IW-1:0];
        lw_data     = free_r;
        free_nxt    = cur_r;
        cnt_nxt     = cnt_r - 1'b1;
        res_vld_nxt = 1'b1;
        res_st_nxt  = hmap_pkg::ST_ERASED;
        res_val_nxt = '0;
        res_cnt_nxt = cnt_r - 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (link_en) begin
      lw_en       = 1'b1;
      lw_addr     = link_node[IW-1:0];
      lw_data     = head_r;
      hw_en       = 1'b1;
      hw_data     = link_node;
      cnt_nxt     = cnt_r + 1'b1;
      res_st_nxt  = hmap_pkg::ST_INSERTED;
      res_val_nxt = '0;
      res_cnt_nxt = cnt_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      free_r    <= NONE;
      hw_r      <= '0;
      cnt_r     <= '0;
      res_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      free_r    <= free_nxt;
      hw_r      <= hw_nxt;
      cnt_r     <= cnt_nxt;
      res_vld_r <= res_vld_nxt;
    end
    op_r      <= op_nxt;
    key_r     <= key_nxt;
    val_r     <= val_nxt;
    bkt_r     <= bkt_nxt;
    head_r    <= head_nxt;
    cur_r     <= cur_nxt;
    prev_r    <= prev_nxt;
    hit_r     <= hit_nxt;
    hitlink_r <= hitlink_nxt;
    hitval_r  <= hitval_nxt;
    res_st_r  <= res_st_nxt;
    res_val_r <= res_val_nxt;
    res_cnt_r <= res_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    key_q  <= key_mem[rd_addr];
    val_q  <= val_mem[rd_addr];
    link_q <= link_mem[rd_addr];
    head_q <= head_mem[q_bucket];
    if (link_en) begin
      key_mem[link_node[IW-1:0]] <= key_r;
    end
    if (vw_en || link_en) begin
      val_mem[link_en ? link_node[IW-1:0] : cur_r[IW-1:0]] <= val_r;
    end
    if (lw_en) begin
      link_mem[lw_addr] <= lw_data;
    end
    if (hw_en) begin
      head_mem[bkt_r] <= hw_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hvld_r <= '0;
    end else if (hw_en) begin
      hvld_r[bkt_r] <= 1'b1;
    end
  end

  assign out_empty       = !res_vld_r;
  assign out_status      = res_st_r;
  assign out_found_value = res_val_r;
  assign out_entry_count = res_cnt_r;

endmodule

[sv/chained_hash_map_unit.sv]
// Flow: the request queue registers each request; the back end then steps
// through S_HEAD, S_WALK once per chain node (one node read per cycle) and
// S_DO; a free-list insert (S_ALLOC) or an erase (S_UNLINK) adds a state.
// The back end serves one request at a time, waiting for each result's pop.
// Reset: synchronous, active low; empties all buckets, the queue and the pool.
// ----------------------------------------------------------------------------
// chained_hash_map_unit
// Key-value map with separate chaining over a fixed node pool.
// ----------------------------------------------------------------------------
module chained_hash_map_unit #(
  parameter int unsigned BUCKETS = 16,
  parameter int unsigned NODES   = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [1:0]                          in_req_type,
  input  logic signed [hmap_pkg::KEY_W-1:0]   in_key,
  input  logic signed [hmap_pkg::VAL_W-1:0]   in_value,
  output logic                                out_empty,
  input  logic                                out_pop,
  output logic [2:0]                          out_status,
  output logic signed [hmap_pkg::VAL_W-1:0]   out_found_value,
  output logic [$clog2(NODES+1)-1:0]          out_entry_count
);

  localparam int unsigned BW = $clog2(BUCKETS);
  localparam int unsigned NW = $clog2(NODES+1);

  logic                       q_valid;
  logic                       q_pop;
  hmap_pkg::op_t              q_op;
  logic [hmap_pkg::KEY_W-1:0] q_key;
  logic [hmap_pkg::VAL_W-1:0] q_value;
  logic [BW-1:0]              q_bucket;

  hmap_front #(.BUCKETS(BUCKETS)) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_req_type (in_req_type),
    .in_key      (in_key),
    .in_value    (in_value),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_op        (q_op),
    .q_key       (q_key),
    .q_value     (q_value),
    .q_bucket    (q_bucket)
  );

  hmap_back #(.BUCKETS(BUCKETS), .NODES(NODES)) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_pop           (q_pop),
    .q_op            (q_op),
    .q_key           (q_key),
    .q_value         (q_value),
    .q_bucket        (q_bucket),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_status      (out_status),
    .out_found_value (out_found_value),
    .out_entry_count (out_entry_count)
  );

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_entry_count <= NW'(NODES))
    else $error("entry count above pool size");

  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != hmap_pkg::ST_FOUND) |-> out_found_value == '0)
    else $error("found value set on a non-found result");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status == hmap_pkg::ST_FULL) |-> out_entry_count == NW'(NODES))
    else $error("table full reported with free nodes");

endmodule
